// ===== hw/rtl/rc4_stream_cipher_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the RC4 stream cipher checker.
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define RC4_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define RC4_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared constants, controller states and the command and status types that
// join the RC4 controller to its datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rc4_pkg;

    localparam int BYTE_W     = 8;
    localparam int PERM_DEPTH = 256;
    localparam int PERM_AW    = $clog2(PERM_DEPTH);
    localparam int KEY_DEPTH  = 256;
    localparam int KEY_AW     = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KEY_LW     = $clog2(KEY_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_RST_FILL,
        ST_IDLE,
        ST_KEY_FILL,
        ST_KRD_N,
        ST_KRD_J,
        ST_KWR_J,
        ST_KWR_N,
        ST_DRD_J,
        ST_DWR_J,
        ST_DWR_I
    } t_state;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_FILL,
        OP_KSA_RD_N,
        OP_KSA_RD_J,
        OP_KSA_WR_J,
        OP_KSA_WR_N,
        OP_GEN_RD_J,
        OP_GEN_WR_J,
        OP_GEN_WR_I
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   accept;
        logic   load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic n_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== hw/rtl/rc4_ram.sv =====
// ----------------------------------------------------------------------------
// rc4_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/rc4_ctrl.sv =====
// ----------------------------------------------------------------------------
// rc4_ctrl
// Sequencer for the identity fill, key scheduling and keystream generation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_mode,
    input  logic              i_last,
    input  rc4_pkg::t_dp_stat i_stat,
    output rc4_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_stall
);

    import rc4_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RST_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RST_FILL: if (i_stat.n_last) n_state = ST_IDLE;
            ST_KEY_FILL: if (i_stat.n_last) n_state = ST_KRD_N;
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_mode) begin
                        n_state = ST_DRD_J;
                    end else if (i_last) begin
                        n_state = ST_KEY_FILL;
                    end
                end
            end
            ST_KRD_N: n_state = ST_KRD_J;
            ST_KRD_J: n_state = ST_KWR_J;
            ST_KWR_J: n_state = ST_KWR_N;
            ST_KWR_N: n_state = i_stat.n_last ? ST_IDLE : ST_KRD_J;
            ST_DRD_J: n_state = ST_DWR_J;
            ST_DWR_J: n_state = ST_DWR_I;
            ST_DWR_I: if (i_stat.out_free) n_state = ST_IDLE;
            default:  n_state = ST_RST_FILL;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = OP_IDLE;
        o_in_stall     = 1'b1;
        unique case (r_state) inside
            ST_RST_FILL,
            ST_KEY_FILL: o_cmd.op = OP_FILL;
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            ST_KRD_N: o_cmd.op = OP_KSA_RD_N;
            ST_KRD_J: o_cmd.op = OP_KSA_RD_J;
            ST_KWR_J: o_cmd.op = OP_KSA_WR_J;
            ST_KWR_N: o_cmd.op = OP_KSA_WR_N;
            ST_DRD_J: o_cmd.op = OP_GEN_RD_J;
            ST_DWR_J: o_cmd.op = OP_GEN_WR_J;
            ST_DWR_I: begin
                o_cmd.op       = OP_GEN_WR_I;
                o_cmd.load_out = i_stat.out_free;
            end
            default: o_cmd.op = OP_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/rc4_dpath.sv =====
// ----------------------------------------------------------------------------
// rc4_dpath
// Permutation and key memories, indices, swap registers and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4_dpath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rc4_pkg::t_dp_cmd           i_cmd,
    output rc4_pkg::t_dp_stat          o_stat,
    input  logic                       i_mode,
    input  logic [rc4_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                       i_last,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [rc4_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_out_last
);

    import rc4_pkg::*;

    logic [PERM_AW-1:0] r_n,   n_n;
    logic [PERM_AW-1:0] r_i,   n_i;
    logic [PERM_AW-1:0] r_j,   n_j;
    logic [KEY_AW-1:0]  r_kpos, n_kpos;
    logic [KEY_LW-1:0]  r_key_len, n_key_len;
    logic [BYTE_W-1:0]  r_si,  n_si;
    logic [BYTE_W-1:0]  r_sj,  n_sj;
    logic [BYTE_W-1:0]  r_in_byte, n_in_byte;
    logic               r_in_last, n_in_last;
    logic               r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]  r_out_byte, n_out_byte;
    logic               r_out_last, n_out_last;

    logic               perm_we;
    logic [PERM_AW-1:0] perm_waddr;
    logic [BYTE_W-1:0]  perm_wdata;
    logic [PERM_AW-1:0] perm_raddr;
    logic [BYTE_W-1:0]  perm_rdata;

    logic               key_we;
    logic [BYTE_W-1:0]  key_rdata;
    logic               key_room;

    logic [PERM_AW-1:0] j_ksa;
    logic [PERM_AW-1:0] j_gen;
    logic [PERM_AW-1:0] t_idx;
    logic [KEY_LW-1:0]  kpos_inc;
    logic [BYTE_W-1:0]  ks_byte;
    logic               out_free;

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PERM_DEPTH)
    ) u_perm_ram (
        .i_clk   (i_clk),
        .i_we    (perm_we),
        .i_waddr (perm_waddr),
        .i_wdata (perm_wdata),
        .i_raddr (perm_raddr),
        .o_rdata (perm_rdata)
    );

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_key_len[KEY_AW-1:0]),
        .i_wdata (i_data_byte),
        .i_raddr (r_kpos),
        .o_rdata (key_rdata)
    );

    assign key_room = (r_key_len < KEY_LW'(KEY_DEPTH));
    assign key_we   = i_cmd.accept & ~i_mode & key_room;

    assign j_ksa    = r_j + perm_rdata + key_rdata;
    assign j_gen    = r_j + perm_rdata;
    assign t_idx    = r_si + r_sj;
    assign kpos_inc = KEY_LW'(r_kpos) + KEY_LW'(1);
    assign out_free = ~r_out_valid | ~i_out_stall;

    // The swap is still in flight when S[S[i] + S[j]] is read, so the two swapped
    // entries are taken from the swap registers.
    always_comb begin
        if (t_idx == r_j) begin
            ks_byte = r_si;
        end else if (t_idx == r_i) begin
            ks_byte = r_sj;
        end else begin
            ks_byte = perm_rdata;
        end
    end

    always_comb begin
        n_n         = r_n;
        n_i         = r_i;
        n_j         = r_j;
        n_kpos      = r_kpos;
        n_key_len   = r_key_len;
        n_si        = r_si;
        n_sj        = r_sj;
        n_in_byte   = r_in_byte;
        n_in_last   = r_in_last;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid & i_out_stall;
        perm_we     = 1'b0;
        perm_waddr  = r_n;
        perm_wdata  = r_sj;
        perm_raddr  = r_i + PERM_AW'(1);

        case (i_cmd.op)
            OP_IDLE: begin
                if (i_cmd.accept) begin
                    if (i_mode) begin
                        n_i       = r_i + PERM_AW'(1);
                        n_in_byte = i_data_byte;
                        n_in_last = i_last;
                    end else begin
                        if (key_room) begin
                            n_key_len = r_key_len + KEY_LW'(1);
                        end
                        if (i_last) begin
                            n_j    = '0;
                            n_kpos = '0;
                        end
                    end
                end
            end
            OP_FILL: begin
                perm_we    = 1'b1;
                perm_wdata = BYTE_W'(r_n);
                n_n        = r_n + PERM_AW'(1);
            end
            OP_KSA_RD_N: begin
                perm_raddr = r_n;
            end
            OP_KSA_RD_J: begin
                n_si       = perm_rdata;
                n_j        = j_ksa;
                perm_raddr = j_ksa;
                n_kpos     = (kpos_inc >= r_key_len) ? '0 : kpos_inc[KEY_AW-1:0];
            end
            OP_KSA_WR_J: begin
                n_sj       = perm_rdata;
                perm_we    = 1'b1;
                perm_waddr = r_j;
                perm_wdata = r_si;
            end
            OP_KSA_WR_N: begin
                perm_we    = 1'b1;
                perm_waddr = r_n;
                perm_wdata = r_sj;
                perm_raddr = r_n + PERM_AW'(1);
                n_n        = r_n + PERM_AW'(1);
                if (o_stat.n_last) begin
                    n_i       = '0;
                    n_j       = '0;
                    n_key_len = '0;
                end
            end
            OP_GEN_RD_J: begin
                n_si       = perm_rdata;
                n_j        = j_gen;
                perm_raddr = j_gen;
            end
            OP_GEN_WR_J: begin
                n_sj       = perm_rdata;
                perm_we    = 1'b1;
                perm_waddr = r_j;
                perm_wdata = r_si;
                perm_raddr = r_si + perm_rdata;
            end
            OP_GEN_WR_I: begin
                perm_we    = 1'b1;
                perm_waddr = r_i;
                perm_wdata = r_sj;
                perm_raddr = t_idx;
                if (i_cmd.load_out) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_in_byte ^ ks_byte;
                    n_out_last  = r_in_last;
                end
            end
            default: begin
                perm_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_kpos      <= '0;
            r_key_len   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_n         <= n_n;
            r_i         <= n_i;
            r_j         <= n_j;
            r_kpos      <= n_kpos;
            r_key_len   <= n_key_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_si       <= n_si;
        r_sj       <= n_sj;
        r_in_byte  <= n_in_byte;
        r_in_last  <= n_in_last;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_stat.n_last   = (r_n == {PERM_AW{1'b1}});
    assign o_stat.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

// ===== hw/rtl/rc4_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// rc4_stream_cipher: one data item at a time, input stalled until its result is loaded.
// Each data item: accept, then the dependent S[j] and S[S[i]+S[j]] reads, with
// the two swap writes sharing the single S-box write port.
// Key byte written on accept; last key byte adds the 256-entry fill and key scheduling.
// Sync reset: identity fill of all 256 S-box entries, input stalled meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4_stream_cipher (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_mode,
    input  logic [rc4_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                       i_last,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [rc4_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_out_last
);

    import rc4_pkg::*;

    // The block holds the RC4 permutation (S-box) in a 256 x 8 memory with one
    // write port and one registered read port, and the key in a second memory
    // of the same shape. Both are instances of the generic RAM.
    //
    // A key item (mode low) is written into the key memory in the cycle it is
    // accepted, as long as the key memory still has room; later key bytes are
    // dropped. The key item marked last starts key scheduling: the S-box is
    // refilled with the identity, one entry per cycle, and then the 256 swap
    // steps run, reading S[j] and writing S[j] and S[n]. Then both indices and
    // the key length return to zero, so the next key item begins a new key.
    //
    // A data item (mode high) steps the keystream generator. The read of
    // S[i+1] is issued while the block waits, so the item needs only two more
    // dependent reads, and the two swap writes share the single write port.
    // The final read of S[S[i]+S[j]] overlaps the swap; the datapath takes the
    // two swapped entries from its own registers when that address hits them.
    //
    // The result sits in an output register. The block goes back to accepting
    // items as soon as the result is loaded; if an earlier result has not been
    // taken yet, the item waits in its last step until the register is free.

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    rc4_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_last     (i_last),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    rc4_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_mode      (i_mode),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

endmodule

// ===== hw/rtl/rc4_checker.sv =====
// ----------------------------------------------------------------------------
// rc4_checker
// Port-level checks on the RC4 stream cipher, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "rc4_stream_cipher_macros.svh"

module rc4_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       i_mode,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [rc4_pkg::BYTE_W-1:0] o_out_byte,
    input logic                       o_out_last
);

    logic                         data_acc;
    logic                         out_wait;
    logic [rc4_pkg::BYTE_W:0]     out_word;

    assign data_acc = i_in_valid & ~o_in_stall & i_mode;
    assign out_wait = o_out_valid & i_out_stall;
    assign out_word = {o_out_byte, o_out_last};

    // Reset empties the output register and starts the S-box fill.
    `RC4_ASSERT_RST(a_rst_out_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `RC4_ASSERT_RST(a_rst_busy, !i_rst_n |=> o_in_stall, "input not stalled during S-box fill")

    // A data item keeps the input stalled while it works through the S-box.
    `RC4_ASSERT(a_data_busy, data_acc |=> o_in_stall, "input open right after a data item")

    // Each fresh result must trace back to an accepted data item.
    `RC4_ASSERT(a_result_timing, $rose(o_out_valid) |-> $past(data_acc, 4), "stray result")

    `RC4_ASSERT(a_out_hold, out_wait |=> o_out_valid && $stable(out_word), "result changed")

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (.*);
